### rtl/core/ecc_pkg.sv
// ----------------------------------------------------------------------------
// ecc_pkg
// Shared constants for the Eulerian circuit check unit.
// ----------------------------------------------------------------------------
package ecc_pkg;

    localparam int LETTER_W      = 5;
    localparam int DEF_MAX_EDGES = 1024;
    localparam int DEF_NODES     = 26;

    localparam logic CMD_ADD  = 1'b0;
    localparam logic CMD_EVAL = 1'b1;

endpackage

### rtl/core/eulerian_circuit_check_unit.sv
// ----------------------------------------------------------------------------
// eulerian_circuit_check_unit
// Loads directed edges between letter nodes and, on an evaluate request,
// reports whether the loaded set admits an Eulerian circuit.
// ----------------------------------------------------------------------------
// Add requests are taken one per cycle while busy is low; each edge does a
// read-modify-write of the row memory (adjacency and out count) and the
// in-count memory. An evaluate request keeps busy high for a drain step
// and S sweeps over the row memory, and the result strobe follows in the
// next cycle; S is what the reachable set needs to settle (1 to NODES).
// Reset clears all control state and the per-entry valid bits, so the store
// reads as empty at once; no clearing pass is run.
// ----------------------------------------------------------------------------
module eulerian_circuit_check_unit #(
    parameter int MAX_EDGES = ecc_pkg::DEF_MAX_EDGES,
    parameter int NODES     = ecc_pkg::DEF_NODES
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic                         cmd,
    input  logic [ecc_pkg::LETTER_W-1:0] src_letter,
    input  logic [ecc_pkg::LETTER_W-1:0] dst_letter,
    output logic                         done,
    output logic                         possible,
    output logic                         overflowed
);

    import ecc_pkg::*;

    localparam int NW = $clog2(NODES);
    localparam int CW = $clog2(MAX_EDGES + 1);
    localparam int AW = NODES + CW;

    typedef enum logic [1:0] {IDLE, DRAIN, SCAN} state_t;

    state_t            state_reg, state_next;
    logic [CW-1:0]     edge_count_reg, edge_count_next;
    logic              overflow_reg, overflow_next;
    logic [NW-1:0]     start_node_reg, start_node_next;
    logic [NODES-1:0]  present_reg, present_next;
    logic [NODES-1:0]  va_reg, va_next;
    logic [NODES-1:0]  vb_reg, vb_next;
    logic              st_vld_reg, st_vld_next;
    logic [NW-1:0]     st_src_reg, st_src_next;
    logic [NW-1:0]     st_dst_reg, st_dst_next;
    logic              fa_vld_reg, fa_vld_next;
    logic [NW-1:0]     fa_addr_reg, fa_addr_next;
    logic [AW-1:0]     fa_data_reg, fa_data_next;
    logic              fb_vld_reg, fb_vld_next;
    logic [NW-1:0]     fb_addr_reg, fb_addr_next;
    logic [CW-1:0]     fb_data_reg, fb_data_next;
    logic [NW-1:0]     scan_idx_reg, scan_idx_next;
    logic              dv_reg, dv_next;
    logic [NW-1:0]     didx_reg, didx_next;
    logic [NODES-1:0]  reached_reg, reached_next;
    logic              bal_ok_reg, bal_ok_next;
    logic              changed_reg, changed_next;
    logic              done_reg, done_next;
    logic              possible_reg, possible_next;
    logic              overflowed_reg, overflowed_next;

    logic              accept;
    logic              edge_ok;
    logic [NW-1:0]     src_idx;
    logic [NW-1:0]     dst_idx;
    logic [NW-1:0]     ra_addr;
    logic [NW-1:0]     rb_addr;
    logic [AW-1:0]     a_q;
    logic [CW-1:0]     b_q;
    logic [AW-1:0]     a_eff;
    logic [CW-1:0]     b_eff;
    logic [AW-1:0]     a_wdata;
    logic [CW-1:0]     b_wdata;
    logic [NODES-1:0]  row_s;
    logic [NODES-1:0]  row_d;
    logic [CW-1:0]     out_d;
    logic [CW-1:0]     in_d;
    logic [NODES-1:0]  reached_new;
    logic              chg;
    logic              bal_ok_new;

    localparam logic [NODES-1:0] ONE_HOT0 = NODES'(1);

    assign accept  = start && !busy;
    assign src_idx = NW'(src_letter);
    assign dst_idx = NW'(dst_letter);
    assign edge_ok = accept && (cmd == CMD_ADD)
                     && (32'(src_letter) < NODES) && (32'(dst_letter) < NODES);

    assign ra_addr = (state_reg == SCAN) ? scan_idx_reg : src_idx;
    assign rb_addr = (state_reg == SCAN) ? scan_idx_reg : dst_idx;

    ecc_ram #(
        .WIDTH (AW),
        .DEPTH (NODES)
    ) u_row_ram (
        .clk   (clk),
        .we    (st_vld_reg),
        .waddr (st_src_reg),
        .wdata (a_wdata),
        .raddr (ra_addr),
        .rdata (a_q)
    );

    ecc_ram #(
        .WIDTH (CW),
        .DEPTH (NODES)
    ) u_in_ram (
        .clk   (clk),
        .we    (st_vld_reg),
        .waddr (st_dst_reg),
        .wdata (b_wdata),
        .raddr (rb_addr),
        .rdata (b_q)
    );

    // Edge update: the write of the previous cycle is forwarded, since the
    // memory returns old data on a read of the entry written in that cycle.
    always_comb
    begin
        if (fa_vld_reg && (fa_addr_reg == st_src_reg))
        begin
            a_eff = fa_data_reg;
        end
        else
        begin
            a_eff = va_reg[st_src_reg] ? a_q : '0;
        end
        if (fb_vld_reg && (fb_addr_reg == st_dst_reg))
        begin
            b_eff = fb_data_reg;
        end
        else
        begin
            b_eff = vb_reg[st_dst_reg] ? b_q : '0;
        end
        row_s   = a_eff[AW-1:CW] | (ONE_HOT0 << st_dst_reg);
        a_wdata = {row_s, a_eff[CW-1:0] + CW'(1)};
        b_wdata = b_eff + CW'(1);
    end

    always_comb
    begin
        row_d       = va_reg[didx_reg] ? a_q[AW-1:CW] : '0;
        out_d       = va_reg[didx_reg] ? a_q[CW-1:0] : '0;
        in_d        = vb_reg[didx_reg] ? b_q : '0;
        reached_new = reached_reg | (reached_reg[didx_reg] ? row_d : '0);
        chg         = (reached_new != reached_reg);
        bal_ok_new  = bal_ok_reg && (out_d == in_d);
    end

    always_comb
    begin
        state_next      = state_reg;
        edge_count_next = edge_count_reg;
        overflow_next   = overflow_reg;
        start_node_next = start_node_reg;
        present_next    = present_reg;
        va_next         = va_reg;
        vb_next         = vb_reg;
        st_vld_next     = 1'b0;
        st_src_next     = src_idx;
        st_dst_next     = dst_idx;
        fa_vld_next     = st_vld_reg;
        fa_addr_next    = st_src_reg;
        fa_data_next    = a_wdata;
        fb_vld_next     = st_vld_reg;
        fb_addr_next    = st_dst_reg;
        fb_data_next    = b_wdata;
        scan_idx_next   = scan_idx_reg;
        dv_next         = 1'b0;
        didx_next       = scan_idx_reg;
        reached_next    = reached_reg;
        bal_ok_next     = bal_ok_reg;
        changed_next    = changed_reg;
        done_next       = 1'b0;
        possible_next   = possible_reg;
        overflowed_next = overflowed_reg;

        if (st_vld_reg)
        begin
            va_next[st_src_reg] = 1'b1;
            vb_next[st_dst_reg] = 1'b1;
        end

        case (state_reg)
            IDLE:
            begin
                if (edge_ok)
                begin
                    if (edge_count_reg == CW'(MAX_EDGES))
                    begin
                        overflow_next = 1'b1;
                    end
                    else
                    begin
                        if (edge_count_reg == '0)
                        begin
                            start_node_next = src_idx;
                        end
                        edge_count_next = edge_count_reg + CW'(1);
                        present_next    = present_reg | (ONE_HOT0 << src_idx)
                                          | (ONE_HOT0 << dst_idx);
                        st_vld_next     = 1'b1;
                    end
                end
                else if (accept && (cmd == CMD_EVAL))
                begin
                    state_next = DRAIN;
                end
            end
            DRAIN:
            begin
                scan_idx_next = '0;
                reached_next  = ONE_HOT0 << start_node_reg;
                bal_ok_next   = 1'b1;
                changed_next  = 1'b0;
                state_next    = SCAN;
            end
            SCAN:
            begin
                scan_idx_next = (32'(scan_idx_reg) == NODES - 1) ? '0
                                : scan_idx_reg + NW'(1);
                dv_next       = 1'b1;
                if (dv_reg)
                begin
                    reached_next = reached_new;
                    bal_ok_next  = bal_ok_new;
                    if (32'(didx_reg) == NODES - 1)
                    begin
                        changed_next = 1'b0;
                        if (!(changed_reg || chg))
                        begin
                            done_next       = 1'b1;
                            possible_next   = (edge_count_reg == '0)
                                              || (bal_ok_new
                                              && ((present_reg & ~reached_new) == '0));
                            overflowed_next = overflow_reg;
                            edge_count_next = '0;
                            overflow_next   = 1'b0;
                            start_node_next = '0;
                            present_next    = '0;
                            va_next         = '0;
                            vb_next         = '0;
                            dv_next         = 1'b0;
                            state_next      = IDLE;
                        end
                    end
                    else
                    begin
                        changed_next = changed_reg || chg;
                    end
                end
            end
            default:
            begin
                state_next = IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= IDLE;
            edge_count_reg <= '0;
            overflow_reg   <= 1'b0;
            start_node_reg <= '0;
            present_reg    <= '0;
            va_reg         <= '0;
            vb_reg         <= '0;
            st_vld_reg     <= 1'b0;
            fa_vld_reg     <= 1'b0;
            fb_vld_reg     <= 1'b0;
            scan_idx_reg   <= '0;
            dv_reg         <= 1'b0;
            reached_reg    <= '0;
            bal_ok_reg     <= 1'b1;
            changed_reg    <= 1'b0;
            done_reg       <= 1'b0;
            possible_reg   <= 1'b0;
            overflowed_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            edge_count_reg <= edge_count_next;
            overflow_reg   <= overflow_next;
            start_node_reg <= start_node_next;
            present_reg    <= present_next;
            va_reg         <= va_next;
            vb_reg         <= vb_next;
            st_vld_reg     <= st_vld_next;
            fa_vld_reg     <= fa_vld_next;
            fb_vld_reg     <= fb_vld_next;
            scan_idx_reg   <= scan_idx_next;
            dv_reg         <= dv_next;
            reached_reg    <= reached_next;
            bal_ok_reg     <= bal_ok_next;
            changed_reg    <= changed_next;
            done_reg       <= done_next;
            possible_reg   <= possible_next;
            overflowed_reg <= overflowed_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_src_reg     <= st_src_next;
        st_dst_reg     <= st_dst_next;
        fa_addr_reg    <= fa_addr_next;
        fa_data_reg    <= fa_data_next;
        fb_addr_reg    <= fb_addr_next;
        fb_data_reg    <= fb_data_next;
        didx_reg       <= didx_next;
    end

    assign busy       = (state_reg != IDLE);
    assign done       = done_reg;
    assign possible   = possible_reg;
    assign overflowed = overflowed_reg;

    a_done_after_scan: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(state_reg == SCAN))
        else $error("Result strobe without a finished scan.");

    a_eval_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd == CMD_EVAL)) |=> busy)
        else $error("Evaluate request did not raise busy.");

    a_no_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == SCAN) |-> !st_vld_reg)
        else $error("Edge write pending during the scan.");

    a_overflow_at_capacity: assert property (@(posedge clk) disable iff (!rst_n)
        overflow_reg |-> (edge_count_reg == CW'(MAX_EDGES)))
        else $error("Overflow flag set below capacity.");

endmodule

### rtl/core/ecc_ram.sv
// ----------------------------------------------------------------------------
// ecc_ram
// Generic simple dual-port RAM with one write port and one registered read
// port. A read of the address written in the same cycle returns old data.
// ----------------------------------------------------------------------------
module ecc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule
